// ----- rtl/ffpa_pkg.sv -----
package ffpa_pkg;

	// Widths of the transaction fields
	localparam int IDX_FIELD_W  = 4;
	localparam int SIZE_FIELD_W = 16;
	localparam int SUM_W        = 24;

	localparam logic [SUM_W-1:0] SUM_MAX = '1;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_REQ  = 1'b1
	} cmd_code_t;

	// Controller -> datapath
	typedef struct packed {
		logic load_wr;    // write hole size, mark hole free
		logic req_start;  // latch request size, rewind scan
		logic scan_en;    // scan holes in index order
		logic out_load;   // move result into output register
	} ctl_cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic hit;        // first fitting free hole found this cycle
		logic miss;       // all holes scanned, none fits
		logic out_ready;  // output register can take a result
	} ctl_sts_t;

endpackage

// ----- rtl/ffpa_ctrl.sv -----
module ffpa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               cmd,
	output logic               in_stall,
	output ffpa_pkg::ctl_cmd_t ctl,
	input  ffpa_pkg::ctl_sts_t sts
);
	import ffpa_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESP
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		state_nxt = state_q;
		ctl       = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (cmd == CMD_LOAD) begin
						ctl.load_wr = 1'b1;
						state_nxt   = ST_RESP;
					end else begin
						ctl.req_start = 1'b1;
						state_nxt     = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				ctl.scan_en = 1'b1;
				if (sts.hit || sts.miss) begin
					state_nxt = ST_RESP;
				end
			end
			ST_RESP: begin
				if (sts.out_ready) begin
					ctl.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

// ----- rtl/ffpa_dpath.sv -----
module ffpa_dpath #(
	parameter int NUM_HOLES  = 16,
	parameter int SIZE_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ffpa_pkg::ctl_cmd_t                ctl,
	output ffpa_pkg::ctl_sts_t                sts,
	input  logic [ffpa_pkg::IDX_FIELD_W-1:0]  hole_index,
	input  logic [ffpa_pkg::SIZE_FIELD_W-1:0] block_size,
	input  logic                              out_stall,
	output logic                              out_valid,
	output logic                              granted,
	output logic [ffpa_pkg::IDX_FIELD_W-1:0]  chosen_hole,
	output logic [ffpa_pkg::SIZE_FIELD_W-1:0] leftover,
	output logic [ffpa_pkg::SUM_W-1:0]        total_leftover
);
	import ffpa_pkg::*;

	localparam int IDX_W = (NUM_HOLES > 1) ? $clog2(NUM_HOLES) : 1;
	localparam int CNT_W = $clog2(NUM_HOLES + 1);
	localparam int ADD_W = ((SUM_W > SIZE_WIDTH) ? SUM_W : SIZE_WIDTH) + 1;

	// hole size table, one read port walked by the scan counter
	logic [SIZE_WIDTH-1:0] hole_mem [NUM_HOLES];
	logic [NUM_HOLES-1:0]  free_q;

	logic [SIZE_WIDTH-1:0] size_in;
	logic [IDX_W-1:0]      waddr;
	logic                  wr_in_range;
	logic                  we;

	logic [SIZE_WIDTH-1:0] size_q;
	logic [CNT_W-1:0]      addr_q;
	logic [IDX_W-1:0]      raddr;
	logic                  issue;

	logic                  vld_s1;
	logic                  free_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic [SIZE_WIDTH-1:0] rd_data_s1;

	logic                  hit;
	logic                  miss;
	logic [SIZE_WIDTH-1:0] diff;
	logic [ADD_W-1:0]      sum_ext;
	logic [SUM_W-1:0]      sum_sat;
	logic [SUM_W-1:0]      sum_q;

	logic                  res_granted_q;
	logic [IDX_W-1:0]      res_idx_q;
	logic [SIZE_WIDTH-1:0] res_left_q;

	logic                  out_valid_q;
	logic                  granted_q;
	logic [IDX_W-1:0]      chosen_q;
	logic [SIZE_WIDTH-1:0] left_q;
	logic [SUM_W-1:0]      total_q;

	assign size_in     = SIZE_WIDTH'(block_size);
	assign wr_in_range = (32'(hole_index) < NUM_HOLES);
	assign waddr       = IDX_W'(hole_index);
	assign we          = ctl.load_wr && wr_in_range;

	assign issue = ctl.scan_en && (addr_q < CNT_W'(NUM_HOLES));
	assign raddr = IDX_W'(addr_q);

	assign hit  = ctl.scan_en && vld_s1 && free_s1 && (rd_data_s1 >= size_q);
	assign miss = ctl.scan_en && !vld_s1 && (addr_q == CNT_W'(NUM_HOLES));
	assign diff = rd_data_s1 - size_q;

	assign sum_ext = ADD_W'(sum_q) + ADD_W'(diff);
	assign sum_sat = (sum_ext > ADD_W'(SUM_MAX)) ? SUM_MAX : SUM_W'(sum_ext);

	always_ff @(posedge clk) begin
		if (we) begin
			hole_mem[waddr] <= size_in;
		end
		if (issue) begin
			rd_data_s1 <= hole_mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q      <= '0;
			addr_q      <= '0;
			vld_s1      <= 1'b0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (we) begin
				free_q[waddr] <= 1'b1;
			end else if (hit) begin
				free_q[idx_s1] <= 1'b0;
			end

			if (ctl.req_start) begin
				addr_q <= '0;
				vld_s1 <= 1'b0;
			end else if (ctl.scan_en) begin
				vld_s1 <= issue;
				if (issue) begin
					addr_q <= addr_q + CNT_W'(1);
				end
			end

			if (hit) begin
				sum_q <= sum_sat;
			end

			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctl.req_start) begin
			size_q <= size_in;
		end
		if (issue) begin
			free_s1 <= free_q[raddr];
			idx_s1  <= raddr;
		end

		if (ctl.load_wr || ctl.req_start) begin
			res_granted_q <= 1'b0;
			res_idx_q     <= '0;
			res_left_q    <= '0;
		end else if (hit) begin
			res_granted_q <= 1'b1;
			res_idx_q     <= idx_s1;
			res_left_q    <= diff;
		end

		if (ctl.out_load) begin
			granted_q <= res_granted_q;
			chosen_q  <= res_idx_q;
			left_q    <= res_left_q;
			total_q   <= sum_q;
		end
	end

	assign sts.hit       = hit;
	assign sts.miss      = miss;
	assign sts.out_ready = !out_valid_q || !out_stall;

	assign out_valid      = out_valid_q;
	assign granted        = granted_q;
	assign chosen_hole    = IDX_FIELD_W'(chosen_q);
	assign leftover       = SIZE_FIELD_W'(left_q);
	assign total_leftover = total_q;

endmodule

// ----- rtl/first_fit_partition_allocator.sv -----
// Flow: a load is accepted in IDLE and its result goes from RESP into the output register;
// a request first scans the hole table (SCAN) until it finds a fitting hole or misses.
// Concurrency: one transaction in flight; the input stalls from acceptance until the result
// is loaded (RESP waits while the output is stalled), after the one-entry-per-cycle scan.
// Reset (arst_n, async, active low): no hole free, running total zero, output empty;
// hole sizes are not cleared; a size only counts in a scan once its hole is written.
module first_fit_partition_allocator #(
	parameter int NUM_HOLES  = 16,
	parameter int SIZE_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              cmd,
	input  logic [ffpa_pkg::IDX_FIELD_W-1:0]  hole_index,
	input  logic [ffpa_pkg::SIZE_FIELD_W-1:0] block_size,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              granted,
	output logic [ffpa_pkg::IDX_FIELD_W-1:0]  chosen_hole,
	output logic [ffpa_pkg::SIZE_FIELD_W-1:0] leftover,
	output logic [ffpa_pkg::SUM_W-1:0]        total_leftover
);
	import ffpa_pkg::*;

	// The controller accepts one transaction in IDLE. A load writes the size table
	// and sets the hole's free bit in the same cycle. A request walks the table
	// from hole 0: each cycle one entry is read (registered), and the entry read in
	// the previous cycle is compared against the request size. The first free
	// entry that fits ends the scan, clears its free bit and bumps the saturating
	// leftover total. The result then moves into the output register, which can
	// still hold an earlier result while the next transaction is being processed.

	ctl_cmd_t ctl;
	ctl_sts_t sts;

	ffpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cmd      (cmd),
		.in_stall (in_stall),
		.ctl      (ctl),
		.sts      (sts)
	);

	ffpa_dpath #(
		.NUM_HOLES  (NUM_HOLES),
		.SIZE_WIDTH (SIZE_WIDTH)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.sts            (sts),
		.hole_index     (hole_index),
		.block_size     (block_size),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.granted        (granted),
		.chosen_hole    (chosen_hole),
		.leftover       (leftover),
		.total_leftover (total_leftover)
	);

	// Controller drives at most one datapath command per cycle
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.load_wr, ctl.req_start, ctl.scan_en, ctl.out_load}))
		else $error("more than one datapath command active");

	// A scan can't both find a hole and run out of holes
	a_hit_miss: assert property (@(posedge clk) disable iff (!arst_n)
		sts.hit |-> !sts.miss)
		else $error("scan hit and miss together");

	// Only one transaction in flight: acceptance closes the input
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input still open after acceptance");

	// A result shows up only through an output load
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(ctl.out_load))
		else $error("output valid without a result load");

endmodule

// ----- verif/tb.sv -----
module tb;

	import ffpa_pkg::*;

	localparam int NUM_HOLES  = 16;
	localparam int SIZE_WIDTH = 16;

	// Expected response for one accepted transaction
	typedef struct {
		logic                    granted;
		logic [IDX_FIELD_W-1:0]  chosen_hole;
		logic [SIZE_FIELD_W-1:0] leftover;
		logic [SUM_W-1:0]        total_leftover;
	} alloc_result_t;

	// Shadow copy of the hole table plus the queue of responses still owed by the block.
	// The table is updated the moment a transaction is accepted, so stimulus code can
	// look at it to aim requests at holes that are free right now.
	class alloc_tracker;
		logic [SIZE_FIELD_W-1:0] hole_size [NUM_HOLES];
		bit                      hole_free [NUM_HOLES];
		logic [SUM_W-1:0]        leftover_sum;
		alloc_result_t           pending_grants[$];
		int                      errors;
		int                      loads;
		int                      requests;
		int                      grants;
		int                      misses;
		bit                      saturated;

		function new();
			foreach (hole_size[k]) begin
				hole_size[k] = '0;
				hole_free[k] = 1'b0;
			end
			leftover_sum = '0;
			errors       = 0;
			loads        = 0;
			requests     = 0;
			grants       = 0;
			misses       = 0;
			saturated    = 1'b0;
		endfunction

		task report(string msg);
			$display("%0t mismatch: %s", $time, msg);
			errors++;
		endtask

		// First-fit prediction for one accepted transaction
		function void note_transaction(cmd_code_t c, logic [IDX_FIELD_W-1:0] idx,
				logic [SIZE_FIELD_W-1:0] sz);
			alloc_result_t r;
			logic [SUM_W:0] wide_sum;
			r.granted     = 1'b0;
			r.chosen_hole = '0;
			r.leftover    = '0;
			if (c == CMD_LOAD) begin
				loads++;
				if (idx < NUM_HOLES) begin
					hole_size[idx] = sz;
					hole_free[idx] = 1'b1;
				end
			end else begin
				requests++;
				for (int k = 0; k < NUM_HOLES; k++) begin
					if (hole_free[k] && hole_size[k] >= sz) begin
						hole_free[k]  = 1'b0;
						r.granted     = 1'b1;
						r.chosen_hole = k[IDX_FIELD_W-1:0];
						r.leftover    = hole_size[k] - sz;
						wide_sum      = {1'b0, leftover_sum} + (SUM_W+1)'(r.leftover);
						if (wide_sum > {1'b0, SUM_MAX}) begin
							leftover_sum = SUM_MAX;
						end else begin
							leftover_sum = wide_sum[SUM_W-1:0];
						end
						if (leftover_sum == SUM_MAX) saturated = 1'b1;
						break;
					end
				end
				if (r.granted) grants++;
				else misses++;
			end
			r.total_leftover = leftover_sum;
			pending_grants.push_back(r);
		endfunction

		task check_result(logic g, logic [IDX_FIELD_W-1:0] h, logic [SIZE_FIELD_W-1:0] lo,
				logic [SUM_W-1:0] tot);
			alloc_result_t e;
			if (pending_grants.size() == 0) begin
				report($sformatf("result with nothing outstanding (granted=%0b hole=%0d)", g, h));
				return;
			end
			e = pending_grants.pop_front();
			if (g !== e.granted)
				report($sformatf("granted %0b, want %0b", g, e.granted));
			if (h !== e.chosen_hole)
				report($sformatf("chosen_hole %0d, want %0d", h, e.chosen_hole));
			if (lo !== e.leftover)
				report($sformatf("leftover %0d, want %0d", lo, e.leftover));
			if (tot !== e.total_leftover)
				report($sformatf("total_leftover %0d, want %0d", tot, e.total_leftover));
		endtask
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic                    cmd;
	logic [IDX_FIELD_W-1:0]  hole_index;
	logic [SIZE_FIELD_W-1:0] block_size;
	logic                    out_valid;
	logic                    out_stall;
	logic                    granted;
	logic [IDX_FIELD_W-1:0]  chosen_hole;
	logic [SIZE_FIELD_W-1:0] leftover;
	logic [SUM_W-1:0]        total_leftover;

	alloc_tracker sb;

	// sender burst state
	int sent       = 0;
	int burst_left = 0;
	// raised by the sender, consumed by the receiver to start a long hold-off
	bit long_hold_req = 1'b0;

	first_fit_partition_allocator #(
		.NUM_HOLES  (NUM_HOLES),
		.SIZE_WIDTH (SIZE_WIDTH)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.hole_index     (hole_index),
		.block_size     (block_size),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.granted        (granted),
		.chosen_hole    (chosen_hole),
		.leftover       (leftover),
		.total_leftover (total_leftover)
	);

	always #5 clk = ~clk;

	// Hard stop: far beyond the slowest legal run (all of the traffic, two long hold-offs,
	// and the drain at the end).
	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	// Response monitor: a transaction leaves the block when valid is high and we are not stalling
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(granted, chosen_hole, leftover, total_leftover);
	end

	// Receiver: switches between stall patterns of random length. A long hold-off
	// is inserted on request so the single transaction in flight backs up and the
	// block has to stall its input while the sender keeps offering.
	initial begin
		int mode;
		int mode_left;
		int hold_cnt;
		int phase;
		mode      = 0;
		mode_left = 0;
		hold_cnt  = 0;
		phase     = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_cnt      = 400;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 3);
					mode_left = $urandom_range(10, 150);
					phase     = $urandom_range(2, 7);
				end
				mode_left--;
				case (mode)
					0: begin
						out_stall <= 1'b0;                      // free-flowing
					end
					1: begin
						out_stall <= ($urandom_range(0, 1) == 1);
					end
					2: begin
						out_stall <= (mode_left % phase == 0);  // periodic blips
					end
					default: begin
						out_stall <= ($urandom_range(0, 4) != 0); // mostly stalled
					end
				endcase
			end
		end
	end

	// Drive one transaction and hold it until accepted. Inter-transaction gaps come
	// from the burst counter; payload is scrambled while valid is low.
	task automatic send_txn(cmd_code_t c, logic [IDX_FIELD_W-1:0] idx,
			logic [SIZE_FIELD_W-1:0] sz);
		int gap;
		in_valid   <= 1'b1;
		cmd        <= c;
		hole_index <= idx;
		block_size <= sz;
		do @(posedge clk); while (in_stall);
		sb.note_transaction(c, idx, sz);
		sent++;
		if (sent == 300 || sent == 1400) long_hold_req = 1'b1;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 24);
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid   <= 1'b0;
				cmd        <= 1'($urandom_range(0, 1));
				hole_index <= IDX_FIELD_W'($urandom_range(0, NUM_HOLES - 1));
				block_size <= SIZE_FIELD_W'($urandom);
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Random free hole index, or -1 when every hole is taken
	function automatic int pick_free_hole();
		int cands[$];
		for (int k = 0; k < NUM_HOLES; k++)
			if (sb.hole_free[k]) cands.push_back(k);
		if (cands.size() == 0) return -1;
		return cands[$urandom_range(0, cands.size() - 1)];
	endfunction

	// Mixed traffic: loads with extreme-heavy sizes, requests aimed at free holes
	// (exact fit, partial fit, zero), blind requests and requests too large for any free hole.
	task automatic random_mix(int n);
		int kind;
		int h;
		int hs;
		int biggest;
		logic [SIZE_FIELD_W-1:0] sz;
		for (int i = 0; i < n; i++) begin
			kind = $urandom_range(0, 99);
			h    = pick_free_hole();
			if (kind < 35 || h < 0 && kind < 60) begin
				case ($urandom_range(0, 7))
					0, 1:    sz = '1;
					2:       sz = '0;
					3:       sz = SIZE_FIELD_W'($urandom_range(1, 64));
					default: sz = SIZE_FIELD_W'($urandom);
				endcase
				send_txn(CMD_LOAD, IDX_FIELD_W'($urandom_range(0, NUM_HOLES - 1)), sz);
			end else if (kind < 75 && h >= 0) begin
				hs = int'(sb.hole_size[h]);
				case ($urandom_range(0, 3))
					0:       sz = SIZE_FIELD_W'(hs);
					1:       sz = '0;
					default: sz = SIZE_FIELD_W'($urandom_range(0, hs));
				endcase
				send_txn(CMD_REQ, IDX_FIELD_W'($urandom_range(0, NUM_HOLES - 1)), sz);
			end else if (kind < 90) begin
				sz = SIZE_FIELD_W'($urandom);
				send_txn(CMD_REQ, IDX_FIELD_W'($urandom_range(0, NUM_HOLES - 1)), sz);
			end else begin
				biggest = -1;
				for (int k = 0; k < NUM_HOLES; k++)
					if (sb.hole_free[k] && int'(sb.hole_size[k]) > biggest)
						biggest = int'(sb.hole_size[k]);
				if (biggest < 65535) sz = SIZE_FIELD_W'($urandom_range(biggest + 1, 65535));
				else sz = '1;
				send_txn(CMD_REQ, IDX_FIELD_W'($urandom_range(0, NUM_HOLES - 1)), sz);
			end
		end
	endtask

	initial begin
		int guard;
		sb = new();
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		cmd        <= CMD_LOAD;
		hole_index <= '0;
		block_size <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed ---
		send_txn(CMD_REQ,  4'd0,  16'd0);       // nothing free after reset: miss
		send_txn(CMD_LOAD, 4'd15, 16'hFFFF);
		send_txn(CMD_LOAD, 4'd0,  16'd0);
		send_txn(CMD_LOAD, 4'd5,  16'd100);
		send_txn(CMD_REQ,  4'd9,  16'd0);       // zero request takes the zero hole
		send_txn(CMD_REQ,  4'd0,  16'd101);     // skips 5, lands in 15
		send_txn(CMD_REQ,  4'd0,  16'd100);     // exact fit
		send_txn(CMD_REQ,  4'd0,  16'd0);       // all used: miss
		send_txn(CMD_LOAD, 4'd5,  16'd200);     // reload a used hole
		send_txn(CMD_LOAD, 4'd5,  16'd300);     // overwrite a free hole
		send_txn(CMD_REQ,  4'd15, 16'hFFFF);    // too big: miss
		send_txn(CMD_LOAD, 4'd10, 16'hFFFF);
		send_txn(CMD_REQ,  4'd0,  16'hFFFF);    // largest request, exact
		send_txn(CMD_REQ,  4'd0,  16'd1);
		send_txn(CMD_LOAD, 4'd3,  16'hAAAA);
		send_txn(CMD_LOAD, 4'd12, 16'h5555);
		send_txn(CMD_REQ,  4'd0,  16'h5555);    // first fit picks 3, not the tighter 12
		send_txn(CMD_REQ,  4'd0,  16'h5555);
		send_txn(CMD_LOAD, 4'd7,  16'h0001);
		send_txn(CMD_REQ,  4'd0,  16'h0002);    // one short: miss
		send_txn(CMD_REQ,  4'd0,  16'h0001);

		random_mix(900);

		// Empty the table, then pump maximum leftovers until the total pins at its max
		while (pick_free_hole() >= 0)
			send_txn(CMD_REQ, IDX_FIELD_W'($urandom_range(0, NUM_HOLES - 1)), 16'd0);
		for (int i = 0; i < 270; i++) begin
			send_txn(CMD_LOAD, IDX_FIELD_W'($urandom_range(0, NUM_HOLES - 1)), 16'hFFFF);
			send_txn(CMD_REQ, IDX_FIELD_W'($urandom_range(0, NUM_HOLES - 1)), 16'd0);
		end

		random_mix(480);

		in_valid <= 1'b0;

		// drain
		guard = 0;
		while (sb.pending_grants.size() != 0 && guard < 50000) begin
			@(posedge clk);
			guard++;
		end
		repeat (NUM_HOLES + 8) @(posedge clk);
		if (sb.pending_grants.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.pending_grants.size()));

		$display("Covered %0d transactions: %0d loads, %0d requests (%0d granted, %0d missed).",
			sent, sb.loads, sb.requests, sb.grants, sb.misses);
		$display("Running total reached saturation: %0s; mismatches: %0d.",
			sb.saturated ? "yes" : "no", sb.errors);
		if (sb.errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
